/* rtl/assert_macros.svh */
// Assertion macros shared by the frame receiver RTL.
// Depends on nothing; taken in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle, disabled while reset is asserted (active low).
`define SEBFR_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("frame receiver assertion failed");

// Implication in the cycle after, disabled while reset is asserted (active low).
`define SEBFR_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("frame receiver assertion failed");

`endif

/* rtl/sebfr_pkg.sv */
// Package for the start/end byte frame receiver: sizes, reset codes,
// register indexes and the control state type. No dependencies.
package sebfr_pkg;

    localparam int BUFFER_DEPTH = 64;
    localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
    localparam int CNT_W        = ADDR_W + 1;
    localparam int BYTE_W       = 8;
    localparam int CFG_IDX_W    = 1;

    localparam logic [BYTE_W-1:0] START_CODE_RST = 8'd35;
    localparam logic [BYTE_W-1:0] END_CODE_RST   = 8'd10;

    localparam logic [CFG_IDX_W-1:0] REG_START_CODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END_CODE   = 1'd1;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_RECV  = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

endpackage

/* rtl/sebfr_store.sv */
// Frame store: single write port, single read port with registered read data.
// Depends on sebfr_pkg for depth and widths.
module sebfr_store (
    input  logic                          aclk,
    input  logic                          wr_en,
    input  logic [sebfr_pkg::ADDR_W-1:0]  wr_addr,
    input  logic [sebfr_pkg::BYTE_W-1:0]  wr_data,
    input  logic                          rd_en,
    input  logic [sebfr_pkg::ADDR_W-1:0]  rd_addr,
    output logic [sebfr_pkg::BYTE_W-1:0]  rd_data
);

    logic [sebfr_pkg::BYTE_W-1:0] mem [sebfr_pkg::BUFFER_DEPTH];
    logic [sebfr_pkg::BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/start_end_byte_frame_receiver.sv */
// Top level of the start/end byte frame receiver: control, counters, output
// register. Depends on sebfr_pkg, sebfr_store and assert_macros.svh.
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tdata = rx_byte
//  m_      | out | m_tvalid/m_tready  | m_tdata = frame_byte, m_tuser = frame_empty,
//          |     |                    | m_tlast = frame_last
//  cfg_    | in  | cfg_wen            | cfg_addr = register index, cfg_wdata = value
//
// Idle and receiving: one input beat per cycle; while receiving, data beats are
// stored in the cycle they arrive. End code: input stalls while the frame is
// read through the store's read register into the output register, one beat per
// cycle, slowed only by m_tready; input resumes as the last beat is registered.
// Empty frame: one beat as soon as the output register is free.
// Reset (aresetn low, synchronous) clears state, counts and m_tvalid and restores
// the default codes; the store itself is not cleared.
`include "assert_macros.svh"

module start_end_byte_frame_receiver (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] rx_byte
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,   // [7:0] frame_byte
    output logic                              m_tuser,   // [0] frame_empty
    output logic                              m_tlast,
    input  logic                              cfg_wen,
    input  logic [sebfr_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [7:0]                        cfg_wdata
);

    sebfr_pkg::state_t state_reg, state_next;

    logic [sebfr_pkg::CNT_W-1:0]  wc_reg, wc_next;
    logic [sebfr_pkg::CNT_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic                         rd_pend_reg, rd_pend_next;
    logic                         rd_last_reg, rd_last_next;
    logic [sebfr_pkg::BYTE_W-1:0] start_code_reg, end_code_reg;

    logic                         m_tvalid_reg, m_tvalid_next;
    logic [sebfr_pkg::BYTE_W-1:0] m_tdata_reg, m_tdata_next;
    logic                         m_tuser_reg, m_tuser_next;
    logic                         m_tlast_reg, m_tlast_next;

    logic                         in_beat;
    logic                         is_start, is_end;
    logic                         out_free, data_load, empty_load, issue;
    logic                         wr_en;
    logic [sebfr_pkg::CNT_W-1:0]  wc_inc;
    logic [sebfr_pkg::BYTE_W-1:0] rd_data;

    assign s_tready = (state_reg != sebfr_pkg::ST_DRAIN);
    assign in_beat  = s_tvalid && s_tready;
    assign is_start = (s_tdata == start_code_reg);
    assign is_end   = (s_tdata == end_code_reg);
    assign wc_inc   = wc_reg + sebfr_pkg::CNT_W'(1);
    assign wr_en    = in_beat && (state_reg == sebfr_pkg::ST_RECV) && !is_start && !is_end;

    assign out_free   = !m_tvalid_reg || m_tready;
    assign data_load  = rd_pend_reg && out_free;
    assign empty_load = (state_reg == sebfr_pkg::ST_DRAIN) &&
                        (wc_reg == '0) && out_free;
    assign issue      = (state_reg == sebfr_pkg::ST_DRAIN) && (rd_ptr_reg < wc_reg) &&
                        (!rd_pend_reg || data_load);

    // Writes finish before the drain starts, so reads never race a write.
    sebfr_store u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wc_reg[sebfr_pkg::ADDR_W-1:0]),
        .wr_data (s_tdata),
        .rd_en   (issue),
        .rd_addr (rd_ptr_reg[sebfr_pkg::ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    always_comb begin
        state_next    = state_reg;
        wc_next       = wc_reg;
        rd_ptr_next   = rd_ptr_reg;
        rd_pend_next  = rd_pend_reg;
        rd_last_next  = rd_last_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;

        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            sebfr_pkg::ST_IDLE: begin
                if (in_beat && is_start) begin
                    state_next = sebfr_pkg::ST_RECV;
                    wc_next    = '0;
                end
            end
            sebfr_pkg::ST_RECV: begin
                if (in_beat) begin
                    if (is_start) begin
                        wc_next = '0;
                    end else if (is_end) begin
                        state_next  = sebfr_pkg::ST_DRAIN;
                        rd_ptr_next = '0;
                    end else begin
                        wc_next = wc_inc;
                        if (wc_inc == sebfr_pkg::CNT_W'(sebfr_pkg::BUFFER_DEPTH)) begin
                            state_next = sebfr_pkg::ST_IDLE;   // overflow: drop frame
                        end
                    end
                end
            end
            sebfr_pkg::ST_DRAIN: begin
                if (issue) begin
                    rd_ptr_next  = rd_ptr_reg + sebfr_pkg::CNT_W'(1);
                    rd_pend_next = 1'b1;
                    rd_last_next = (rd_ptr_reg + sebfr_pkg::CNT_W'(1) == wc_reg);
                end else if (data_load) begin
                    rd_pend_next = 1'b0;
                end
                if (data_load) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = rd_data;
                    m_tuser_next  = 1'b0;
                    m_tlast_next  = rd_last_reg;
                    if (rd_last_reg) begin
                        state_next = sebfr_pkg::ST_IDLE;
                    end
                end else if (empty_load) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = '0;
                    m_tuser_next  = 1'b1;
                    m_tlast_next  = 1'b1;
                    state_next    = sebfr_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sebfr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= sebfr_pkg::ST_IDLE;
            wc_reg         <= '0;
            rd_ptr_reg     <= '0;
            rd_pend_reg    <= 1'b0;
            rd_last_reg    <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            start_code_reg <= sebfr_pkg::START_CODE_RST;
            end_code_reg   <= sebfr_pkg::END_CODE_RST;
        end else begin
            state_reg    <= state_next;
            wc_reg       <= wc_next;
            rd_ptr_reg   <= rd_ptr_next;
            rd_pend_reg  <= rd_pend_next;
            rd_last_reg  <= rd_last_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wen) begin
                case (cfg_addr)
                    sebfr_pkg::REG_START_CODE: start_code_reg <= cfg_wdata;
                    sebfr_pkg::REG_END_CODE:   end_code_reg   <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    `SEBFR_ASSERT_NOW(a_recv_count_room, aclk, aresetn,
        state_reg == sebfr_pkg::ST_RECV,
        wc_reg < sebfr_pkg::CNT_W'(sebfr_pkg::BUFFER_DEPTH))
    `SEBFR_ASSERT_NOW(a_read_only_in_drain, aclk, aresetn,
        rd_pend_reg, state_reg == sebfr_pkg::ST_DRAIN)
    `SEBFR_ASSERT_NOW(a_read_ptr_bound, aclk, aresetn,
        state_reg == sebfr_pkg::ST_DRAIN, rd_ptr_reg <= wc_reg)
    `SEBFR_ASSERT_NEXT(a_last_ends_drain, aclk, aresetn,
        data_load && rd_last_reg, state_reg == sebfr_pkg::ST_IDLE && m_tlast)

endmodule
